FILE: hw/rtl/pngargb_pkg.sv
// ----------------------------------------------------------------------------
// pngargb_pkg
// Shared types, codes and helpers for the scanline to ARGB1555 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pngargb_pkg;

   // palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
   localparam int PAL_ADDR_W      = 10;
   localparam logic [PAL_ADDR_W-1:0] ALPHA_BASE = 10'd768;

   // divide by three through a reciprocal, exact for addresses below the alpha base
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   localparam int RECIP3_PW    = 2 * PAL_ADDR_W;

   // byte lanes of one palette entry
   localparam logic [1:0] LANE_RED   = 2'd0;
   localparam logic [1:0] LANE_GREEN = 2'd1;
   localparam logic [1:0] LANE_BLUE  = 2'd2;
   localparam logic [1:0] LANE_ALPHA = 2'd3;

   // pixel formats
   localparam logic [1:0] FMT_RGB     = 2'd0;
   localparam logic [1:0] FMT_RGBA    = 2'd1;
   localparam logic [1:0] FMT_INDEXED = 2'd2;
   localparam logic [1:0] FMT_UNUSED  = 2'd3;

   // index width that packs one index per byte
   localparam logic [3:0] INDEX_BITS_BYTE = 4'd8;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_HAS_ALPHA = 2'd2;

   // request mode
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_PAL_WRITE = 1'b1;

   typedef logic [3:0][7:0] pal_entry_type;

   typedef struct packed {
      logic                  en;
      logic [PAL_ADDR_W-1:0] addr;
      logic [7:0]            data;
   } pal_wr_type;

   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr_a;
      logic [PAL_AW-1:0] addr_b;
   } pal_rd_type;

   // opacity bit over the top five bits of each color byte
   function automatic logic [15:0] pack_word(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic opaque);
      pack_word = {opaque, r[7:3], g[7:3], b[7:3]};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pngargb_palette.sv
// ----------------------------------------------------------------------------
// pngargb_palette
// Palette store: one entry per word with four byte lanes, byte writes from
// palette address decode, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module pngargb_palette (
   input  wire                          clock,
   input  pngargb_pkg::pal_wr_type      wr,
   input  pngargb_pkg::pal_rd_type      rd,
   output pngargb_pkg::pal_entry_type   rd_a,
   output pngargb_pkg::pal_entry_type   rd_b
);
   import pngargb_pkg::*;

   pal_entry_type palette_mem_ff [PALETTE_ENTRIES];
   pal_entry_type rd_a_ff;
   pal_entry_type rd_b_ff;

   logic [RECIP3_PW-1:0]  quot_prod;
   logic [7:0]            col_entry;
   logic [PAL_ADDR_W-1:0] col_rem;
   logic [PAL_ADDR_W-1:0] alpha_off;
   logic                  in_color;
   logic                  wr_ok;
   logic [7:0]            wr_entry;
   logic [1:0]            wr_lane;

   // color byte address splits into entry and lane, alpha bytes follow the base
   assign quot_prod = RECIP3_PW'(wr.addr) * RECIP3_PW'(RECIP3);
   assign col_entry = quot_prod[RECIP3_SHIFT +: 8];
   assign col_rem   = wr.addr - {1'b0, col_entry, 1'b0} - {2'b00, col_entry};
   assign alpha_off = wr.addr - ALPHA_BASE;
   assign in_color  = (wr.addr < ALPHA_BASE);

   always_comb begin
      if (in_color) begin
         wr_entry = col_entry;
         wr_lane  = col_rem[1:0];
         wr_ok    = ({1'b0, col_entry} < 9'(PALETTE_ENTRIES));
      end else begin
         wr_entry = alpha_off[7:0];
         wr_lane  = LANE_ALPHA;
         wr_ok    = (alpha_off < PAL_ADDR_W'(PALETTE_ENTRIES));
      end
   end

   // byte-lane write
   always_ff @(posedge clock) begin
      if (wr.en && wr_ok) begin
         palette_mem_ff[wr_entry[PAL_AW-1:0]][wr_lane] <= wr.data;
      end
   end

   // two read ports, data registered
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_a_ff <= palette_mem_ff[rd.addr_a];
         rd_b_ff <= palette_mem_ff[rd.addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/png_scanline_to_argb1555.sv
// ----------------------------------------------------------------------------
// png_scanline_to_argb1555
// Turns truecolor, truecolor-alpha and indexed pixels into ARGB1555 words.
// ----------------------------------------------------------------------------
// A taken item passes the stage 1 registers and then the output register.
// Throughput: one item per cycle for single-word items while rsp_stall is low;
// an indexed byte whose index width is not eight gives two words; the next
// item waits until the second leaves the pending slot. Palette writes
// produce no result. Reset clears the pipeline and loads the register
// defaults; palette contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_to_argb1555 (
   input  wire                              clock,
   input  wire                              reset,
   // configuration
   input  wire                              csr_write_en,
   input  wire [pngargb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [pngargb_pkg::CSR_DATA_W-1:0] csr_write_data,
   // request channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_mode,
   input  wire [7:0]                        req_red,
   input  wire [7:0]                        req_green,
   input  wire [7:0]                        req_blue,
   input  wire [7:0]                        req_alpha,
   input  wire [7:0]                        req_index_byte,
   input  wire [pngargb_pkg::PAL_ADDR_W-1:0] req_pal_addr,
   input  wire [7:0]                        req_pal_data,
   // response channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [15:0]                      rsp_sprite_word,
   output logic                             rsp_last_of_run
);
   import pngargb_pkg::*;

   // configuration registers
   logic [1:0] pixel_format_ff;
   logic [3:0] index_bits_ff;
   logic       palette_has_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff      <= FMT_RGB;
         index_bits_ff        <= INDEX_BITS_BYTE;
         palette_has_alpha_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT:      pixel_format_ff      <= csr_write_data[1:0];
            CSR_INDEX_BITS:        index_bits_ff        <= csr_write_data[3:0];
            CSR_PALETTE_HAS_ALPHA: palette_has_alpha_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // stage 1 and output registers
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_indexed_ff;
   logic        s1_two_ff;
   logic        s1_ok_a_ff, s1_ok_b_ff;
   logic        s1_has_alpha_ff;
   logic [15:0] s1_tc_word_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_word_ff, rsp_word_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [15:0] pend_word_ff, pend_word_in;

   logic        req_xfer;
   logic        produces;
   logic        is_two;
   logic [7:0]  idx_a, idx_b;
   logic        out_free;
   logic        s1_adv;

   pal_wr_type    pal_wr;
   pal_rd_type    pal_rd;
   pal_entry_type ent_a, ent_b;
   logic [15:0]   word_a, word_b;
   logic [15:0]   word0, word1;

   // input transfer and decode
   assign out_free  = !pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_xfer  = req_valid && !req_stall;

   assign produces = (req_mode == MODE_PIXEL) && (pixel_format_ff != FMT_UNUSED);
   assign is_two   = (pixel_format_ff == FMT_INDEXED) && (index_bits_ff != INDEX_BITS_BYTE);
   assign idx_a    = is_two ? {4'h0, req_index_byte[7:4]} : req_index_byte;
   assign idx_b    = {4'h0, req_index_byte[3:0]};

   // palette access
   assign pal_wr.en     = req_xfer && (req_mode == MODE_PAL_WRITE);
   assign pal_wr.addr   = req_pal_addr;
   assign pal_wr.data   = req_pal_data;
   assign pal_rd.en     = req_xfer && (req_mode == MODE_PIXEL);
   assign pal_rd.addr_a = idx_a[PAL_AW-1:0];
   assign pal_rd.addr_b = idx_b[PAL_AW-1:0];

   pngargb_palette u_palette (
      .clock (clock),
      .wr    (pal_wr),
      .rd    (pal_rd),
      .rd_a  (ent_a),
      .rd_b  (ent_b)
   );

   assign s1_valid_in = (req_xfer && produces) || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage 1 payload, loaded with the palette read
   always_ff @(posedge clock) begin
      if (req_xfer && produces) begin
         s1_indexed_ff   <= (pixel_format_ff == FMT_INDEXED);
         s1_two_ff       <= is_two;
         s1_ok_a_ff      <= ({1'b0, idx_a} < 9'(PALETTE_ENTRIES));
         s1_ok_b_ff      <= ({1'b0, idx_b} < 9'(PALETTE_ENTRIES));
         s1_has_alpha_ff <= palette_has_alpha_ff;
         s1_tc_word_ff   <= pack_word(req_red, req_green, req_blue,
                                      (pixel_format_ff == FMT_RGB) || (req_alpha != 8'h00));
      end
   end

   // palette entries to words, out-of-range index gives transparent black; truecolor items keep their stage 1 word
   always_comb begin
      word_a = 16'h0000;
      word_b = 16'h0000;
      if (s1_ok_a_ff) begin
         word_a = pack_word(ent_a[LANE_RED], ent_a[LANE_GREEN], ent_a[LANE_BLUE],
                            !s1_has_alpha_ff || (ent_a[LANE_ALPHA] != 8'h00));
      end
      if (s1_ok_b_ff) begin
         word_b = pack_word(ent_b[LANE_RED], ent_b[LANE_GREEN], ent_b[LANE_BLUE],
                            !s1_has_alpha_ff || (ent_b[LANE_ALPHA] != 8'h00));
      end
      word0 = s1_indexed_ff ? word_a : s1_tc_word_ff;
      word1 = word_b;
   end

   // output register with one pending slot for the low-nibble word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      if (s1_adv) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = word0;
         rsp_last_in   = !s1_two_ff;
         pend_valid_in = s1_two_ff;
         pend_word_in  = word1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         if (pend_valid_ff) begin
            rsp_word_in   = pend_word_ff;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sprite_word = rsp_word_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // checks
   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending word without a word on the output");

   a_pend_not_last: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !rsp_last_ff)
      else $error("first word of a pair marked last");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with stage 1 empty");

   a_pair_fills_pend: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_two_ff) |=> pend_valid_ff)
      else $error("second word of a pair lost");

endmodule

`default_nettype wire
